### rtl/clrb_pkg.sv
// Shared types, constants and helper functions for the console line ring buffer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package clrb_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int MAX_READ  = 64;
    localparam int CPY_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int LINE_W    = 8;
    localparam int LEFT_W    = 8;

    localparam logic [LINE_W-1:0] LINES_MAX    = 8'd255;
    localparam logic [CHAR_W-1:0] LINE_FEED    = 8'h0A;
    localparam logic [CHAR_W-1:0] CARRIAGE_RET = 8'h0D;

    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [PTR_W-1:0]  rd_ptr;
        logic [CNT_W-1:0]  count;
        logic [CPY_W-1:0]  copied;
        logic [CPY_W-1:0]  want;
        logic [LINE_W-1:0] lines;
        logic [CHAR_W-1:0] ch;
    } t_step_in;

    typedef struct packed {
        logic [PTR_W-1:0]  rd_ptr;
        logic [CNT_W-1:0]  count;
        logic [CPY_W-1:0]  copied;
        logic [LINE_W-1:0] lines;
        logic              stop;
    } t_step_out;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(BUF_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    function automatic logic is_line_end(input logic [CHAR_W-1:0] c);
        return (c == LINE_FEED) || (c == CARRIAGE_RET);
    endfunction

endpackage

`default_nettype wire

### rtl/console_line_ring_buffer.sv
// Console receive ring buffer with line discipline. After a receive transfer the input is
// ready again on the next cycle. Each copied byte of a read passes an address cycle, then
// the store's registered read port; an empty read skips the address cycle. A read can also
// stall on the result register; the input is not ready until the last result is loaded.
// Reset (synchronous, active low) clears pointers, counts and pending lines and selects
// line mode; the character store is not cleared and needs no clearing pass.
`default_nettype none

module console_line_ring_buffer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,   // require_full_line
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // [7:0] rx_byte, [14:8] read_max, [15] zero
    input  wire logic        s_axis_tuser,    // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,    // [7:0] data_byte, [14:8] copied_so_far,
                                              // [22:15] stored_after, [23] zero
    output logic             m_axis_tuser,    // has_data
    output logic             m_axis_tlast     // last
);

    clrb_pkg::t_mem_req              mem_req;
    logic [clrb_pkg::CHAR_W-1:0]     mem_rd_data;
    clrb_pkg::t_step_in              step_in;
    clrb_pkg::t_step_out             step_out;

    clrb_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    clrb_step u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    clrb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .o_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser),
        .o_m_tlast     (m_axis_tlast),
        .o_mem_req     (mem_req),
        .i_mem_rd_data (mem_rd_data),
        .o_step        (step_in),
        .i_step        (step_out)
    );

endmodule

`default_nettype wire

### rtl/clrb_store.sv
// Character store of the ring: one write port, one read port with registered data.
// Depends on clrb_pkg for depth, widths and the request struct.
`default_nettype none

module clrb_store (
    input  wire logic                      i_clk,
    input  wire clrb_pkg::t_mem_req        i_req,
    output logic [clrb_pkg::CHAR_W-1:0]    o_rd_data
);

    logic [clrb_pkg::CHAR_W-1:0] r_mem [clrb_pkg::BUF_DEPTH];
    logic [clrb_pkg::CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/clrb_step.sv
// Per-byte read step: advances the read pointer, count and copy tally for one byte.
// Depends on clrb_pkg for the step structs and ring helpers.
`default_nettype none

module clrb_step (
    input  wire clrb_pkg::t_step_in   i_step,
    output clrb_pkg::t_step_out       o_step
);

    logic eol;

    always_comb begin
        eol           = clrb_pkg::is_line_end(i_step.ch);
        o_step.rd_ptr = clrb_pkg::ring_next(i_step.rd_ptr);
        o_step.count  = i_step.count - clrb_pkg::CNT_W'(1);
        o_step.copied = i_step.copied + clrb_pkg::CPY_W'(1);
        if (eol && (i_step.lines != '0)) begin
            o_step.lines = i_step.lines - clrb_pkg::LINE_W'(1);
        end else begin
            o_step.lines = i_step.lines;
        end
        // stop after a line end, a full request or an emptied ring
        o_step.stop = eol || (o_step.copied >= i_step.want) || (o_step.count == '0);
    end

endmodule

`default_nettype wire

### rtl/clrb_ctrl.sv
// Sequencer of the ring: pointers, counts, line mode and the result register.
// Depends on clrb_pkg; drives clrb_store and feeds clrb_step once per copied byte.
`default_nettype none

module clrb_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic                         i_cfg_wr_data,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [15:0]                  i_s_tdata,
    input  wire logic                         i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [23:0]                       o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    output clrb_pkg::t_mem_req                o_mem_req,
    input  wire logic [clrb_pkg::CHAR_W-1:0]  i_mem_rd_data,
    output clrb_pkg::t_step_in                o_step,
    input  wire clrb_pkg::t_step_out          i_step
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;

    logic [1:0]                    r_state,     n_state;
    logic [clrb_pkg::PTR_W-1:0]    r_rd_ptr,    n_rd_ptr;
    logic [clrb_pkg::PTR_W-1:0]    r_wr_ptr,    n_wr_ptr;
    logic [clrb_pkg::CNT_W-1:0]    r_count,     n_count;
    logic [clrb_pkg::LINE_W-1:0]   r_lines,     n_lines;
    logic                          r_full_line, n_full_line;
    logic [clrb_pkg::CPY_W-1:0]    r_want,      n_want;
    logic [clrb_pkg::CPY_W-1:0]    r_copied,    n_copied;
    logic                          r_empty,     n_empty;
    logic                          r_out_valid, n_out_valid;
    logic [clrb_pkg::CHAR_W-1:0]   r_out_char,  n_out_char;
    logic                          r_out_has,   n_out_has;
    logic                          r_out_last,  n_out_last;
    logic [clrb_pkg::CPY_W-1:0]    r_out_cpy,   n_out_cpy;
    logic [clrb_pkg::LEFT_W-1:0]   r_out_left,  n_out_left;

    logic                          in_fire;
    logic                          out_free;
    logic                          avail;
    logic [clrb_pkg::CHAR_W-1:0]   rx_char;
    logic [clrb_pkg::CPY_W-1:0]    req_max;
    logic [clrb_pkg::CPY_W-1:0]    want_clip;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign rx_char    = i_s_tdata[7:0];
    assign req_max    = i_s_tdata[14:8];
    assign want_clip  = (req_max > clrb_pkg::CPY_W'(clrb_pkg::MAX_READ))
                        ? clrb_pkg::CPY_W'(clrb_pkg::MAX_READ) : req_max;
    assign avail      = r_full_line ? (r_lines != '0) : (r_count != '0);

    always_comb begin
        o_step.rd_ptr = r_rd_ptr;
        o_step.count  = r_count;
        o_step.copied = r_copied;
        o_step.want   = r_want;
        o_step.lines  = r_lines;
        o_step.ch     = i_mem_rd_data;
    end

    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_lines     = r_lines;
        n_full_line = i_cfg_wr_en ? i_cfg_wr_data : r_full_line;
        n_want      = r_want;
        n_copied    = r_copied;
        n_empty     = r_empty;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_char  = r_out_char;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        n_out_cpy   = r_out_cpy;
        n_out_left  = r_out_left;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_wr_ptr;
        o_mem_req.wr_data = rx_char;
        o_mem_req.rd_en   = 1'b0;
        o_mem_req.rd_addr = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_s_tuser == clrb_pkg::CMD_RX) begin
                        o_mem_req.wr_en = 1'b1;
                        n_wr_ptr = clrb_pkg::ring_next(r_wr_ptr);
                        // full ring: drop the oldest byte, count holds
                        if (r_count >= clrb_pkg::CNT_W'(clrb_pkg::BUF_DEPTH)) begin
                            n_rd_ptr = clrb_pkg::ring_next(r_rd_ptr);
                        end else begin
                            n_count = r_count + clrb_pkg::CNT_W'(1);
                        end
                        if (clrb_pkg::is_line_end(rx_char) &&
                            (r_lines != clrb_pkg::LINES_MAX)) begin
                            n_lines = r_lines + clrb_pkg::LINE_W'(1);
                        end
                    end else begin
                        n_want   = want_clip;
                        n_copied = '0;
                        if ((want_clip == '0) || !avail || (r_count == '0)) begin
                            n_empty = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            n_empty = 1'b0;
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                o_mem_req.rd_en = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_empty) begin
                        n_out_char = '0;
                        n_out_has  = 1'b0;
                        n_out_last = 1'b1;
                        n_out_cpy  = '0;
                        n_out_left = clrb_pkg::LEFT_W'(r_count);
                        n_state    = S_IDLE;
                    end else begin
                        n_rd_ptr   = i_step.rd_ptr;
                        n_count    = i_step.count;
                        n_copied   = i_step.copied;
                        n_lines    = i_step.lines;
                        n_out_char = i_mem_rd_data;
                        n_out_has  = 1'b1;
                        n_out_last = i_step.stop;
                        n_out_cpy  = i_step.copied;
                        n_out_left = clrb_pkg::LEFT_W'(i_step.count);
                        n_state    = i_step.stop ? S_IDLE : S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_lines     <= '0;
            r_full_line <= 1'b1;
            r_want      <= '0;
            r_copied    <= '0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_lines     <= n_lines;
            r_full_line <= n_full_line;
            r_want      <= n_want;
            r_copied    <= n_copied;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
        r_out_cpy  <= n_out_cpy;
        r_out_left <= n_out_left;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_left, r_out_cpy, r_out_char};
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

### sim/tb_console_line_ring_buffer.sv
// Self-checking testbench for console_line_ring_buffer: directed and random receive/read
// traffic against a behavioral predictor of the ring, its line count and its line mode.
// Depends on clrb_pkg and rtl/console_line_ring_buffer.sv.

module tb_console_line_ring_buffer;

    localparam int BUF_DEPTH = clrb_pkg::BUF_DEPTH;
    localparam int MAX_READ  = clrb_pkg::MAX_READ;
    localparam int CHAR_W    = clrb_pkg::CHAR_W;
    localparam int CPY_W     = clrb_pkg::CPY_W;
    localparam int LEFT_W    = clrb_pkg::LEFT_W;
    localparam int LINE_W    = clrb_pkg::LINE_W;

    localparam logic [CHAR_W-1:0] LINE_FEED    = clrb_pkg::LINE_FEED;
    localparam logic [CHAR_W-1:0] CARRIAGE_RET = clrb_pkg::CARRIAGE_RET;
    localparam logic [LINE_W-1:0] LINES_MAX    = clrb_pkg::LINES_MAX;
    localparam logic              CMD_RX       = clrb_pkg::CMD_RX;
    localparam logic              CMD_READ     = clrb_pkg::CMD_READ;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] data_byte;
        logic              has_data;
        logic              is_last;
        logic [CPY_W-1:0]  copied;
        logic [LEFT_W-1:0] stored_after;
    } t_read_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b1;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Shadow of the ring, the pending line count and the line-mode register
    logic [CHAR_W-1:0] ring_chars [BUF_DEPTH];
    int                ring_head  = 0;
    int                ring_tail  = 0;
    int                ring_fill  = 0;
    int                line_count = 0;
    logic              line_mode  = 1'b1;

    t_read_beat expected_beats[$];
    int         error_count    = 0;
    int         quiet_cycles   = 0;
    bit         sender_gaps_on = 1'b1;
    bit         sink_stalls_on = 1'b1;

    console_line_ring_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_empty_read();
        t_read_beat beat;
        beat = '{data_byte: '0, has_data: 1'b0, is_last: 1'b1, copied: '0,
                 stored_after: LEFT_W'(ring_fill)};
        expected_beats.push_back(beat);
    endfunction

    // Update the shadow ring for one accepted transfer and queue the results it causes
    function automatic void apply_console_item(input logic cmd, input logic [CHAR_W-1:0] rx,
                                               input logic [CPY_W-1:0] read_max);
        int                want;
        int                copied;
        logic              avail;
        logic              line_end;
        logic              stop;
        logic [CHAR_W-1:0] ch;
        t_read_beat        beat;
        if (cmd == CMD_RX) begin
            // Full ring: drop the oldest byte; a dropped line end keeps its count
            if (ring_fill >= BUF_DEPTH) begin
                ring_head = (ring_head + 1) % BUF_DEPTH;
                ring_fill--;
            end
            ring_chars[ring_tail] = rx;
            ring_tail = (ring_tail + 1) % BUF_DEPTH;
            ring_fill++;
            if ((rx == LINE_FEED || rx == CARRIAGE_RET) && line_count < int'(LINES_MAX))
                line_count++;
            return;
        end
        want  = (int'(read_max) > MAX_READ) ? MAX_READ : int'(read_max);
        avail = line_mode ? (line_count != 0) : (ring_fill != 0);
        if (want == 0 || !avail) begin
            push_empty_read();
            return;
        end
        copied = 0;
        while (copied < want && ring_fill != 0) begin
            ch        = ring_chars[ring_head];
            line_end  = (ch == LINE_FEED) || (ch == CARRIAGE_RET);
            ring_head = (ring_head + 1) % BUF_DEPTH;
            ring_fill--;
            copied++;
            if (line_end && line_count != 0)
                line_count--;
            stop = line_end || copied >= want || ring_fill == 0;
            beat = '{data_byte: ch, has_data: 1'b1, is_last: stop, copied: CPY_W'(copied),
                     stored_after: LEFT_W'(ring_fill)};
            expected_beats.push_back(beat);
            if (stop)
                break;
        end
        if (copied == 0)
            push_empty_read();
    endfunction

    function automatic logic [CHAR_W-1:0] pick_text_char();
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [CPY_W-1:0] pick_read_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CPY_W'($urandom_range(MAX_READ + 1, 127));
        return CPY_W'($urandom_range(1, MAX_READ));
    endfunction

    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] rx,
                             input logic [CPY_W-1:0] read_max);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, read_max, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_console_item(cmd, rx, read_max);
    endtask

    // Unused fields carry random values: the block must ignore them
    task automatic send_rx(input logic [CHAR_W-1:0] ch);
        send_item(CMD_RX, ch, CPY_W'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [CPY_W-1:0] read_max);
        send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), read_max);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        // A trailing receive may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_mode(input logic mode);
        hold_until_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        line_mode = mode;
    endtask

    task automatic test_empty_reads();
        send_read(7'd5);
        send_read(7'd0);
    endtask

    task automatic test_line_reads();
        send_rx(8'h00);
        send_rx("a");
        send_rx(LINE_FEED);
        send_rx(8'hFF);
        send_rx(CARRIAGE_RET);
        send_read(7'd64);
        send_read(7'd0);
        send_read(7'd1);
        send_read(7'd127);
        send_read(7'd10);
        // A partial line is not readable in line mode
        send_rx("p");
        send_read(7'd5);
    endtask

    task automatic test_raw_reads();
        write_line_mode(1'b0);
        send_rx("x");
        send_rx("y");
        send_rx("z");
        send_read(7'd2);
        send_read(7'd64);
        send_read(7'd3);
        send_rx("q");
        send_rx(CARRIAGE_RET);
        send_read(7'd100);
    endtask

    task automatic test_random_traffic(input int item_total, input logic mode,
                                       input bit pause_midway);
        int sent;
        int line_len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        write_line_mode(mode);
        while (sent < item_total) begin
            if (pause_midway && !paused && sent >= item_total / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                line_len = $urandom_range(0, 20);
                repeat (line_len) send_rx(pick_text_char());
                send_rx($urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RET);
                sent += line_len + 1;
                repeat ($urandom_range(0, 2)) begin
                    send_read(pick_read_len());
                    sent++;
                end
            end else begin
                if ($urandom_range(0, 1))
                    send_rx(CHAR_W'($urandom_range(0, 255)));
                else
                    send_read(pick_read_len());
                sent++;
            end
        end
    endtask

    task automatic test_ring_overflow();
        logic [CHAR_W-1:0] ch;
        write_line_mode(1'b1);
        hold_until_drained();
        // Drain whatever is left so the overflow starts from an empty ring
        write_line_mode(1'b0);
        while (ring_fill != 0) send_read(7'd64);
        write_line_mode(1'b1);
        send_rx(LINE_FEED);
        repeat (BUF_DEPTH + 1) begin
            do ch = CHAR_W'($urandom_range(0, 255));
            while (ch == LINE_FEED || ch == CARRIAGE_RET);
            send_rx(ch);
        end
        send_read(7'd64);
        write_line_mode(1'b0);
        send_read(7'd127);
        // Line count survives with an empty ring: the read copies nothing
        write_line_mode(1'b1);
        send_read(7'd64);
    endtask

    task automatic test_line_count_saturation();
        repeat (256) send_rx($urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RET);
        repeat (3) send_read(pick_read_len());
        write_line_mode(1'b0);
        repeat (3) send_read(7'd64);
    endtask

    // Stall the result side in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_read_beat got;
        t_read_beat want_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{data_byte: m_axis_tdata[7:0], has_data: m_axis_tuser,
                    is_last: m_axis_tlast, copied: m_axis_tdata[14:8],
                    stored_after: m_axis_tdata[22:15]};
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result byte=%02h has=%0d last=%0d copied=%0d left=%0d",
                         $time, got.data_byte, got.has_data, got.is_last, got.copied,
                         got.stored_after);
                error_count++;
            end else begin
                want_beat = expected_beats.pop_front();
                if (got !== want_beat) begin
                    $display("%0t: mismatch expected byte=%02h has=%0d last=%0d copied=%0d left=%0d",
                             $time, want_beat.data_byte, want_beat.has_data,
                             want_beat.is_last, want_beat.copied, want_beat.stored_after);
                    $display("%0t:          actual byte=%02h has=%0d last=%0d copied=%0d left=%0d",
                             $time, got.data_byte, got.has_data, got.is_last, got.copied,
                             got.stored_after);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_reads();
        test_line_reads();
        test_raw_reads();
        test_random_traffic(20, 1'b1, 1'b1);
        test_random_traffic(20, 1'b0, 1'b0);
        test_ring_overflow();
        hold_until_drained();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_line_count_saturation();
        hold_until_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/clrb_pkg.sv
rtl/clrb_store.sv
rtl/clrb_step.sv
rtl/clrb_ctrl.sv
rtl/console_line_ring_buffer.sv
sim/tb_console_line_ring_buffer.sv
